### hdl/ffha_pkg.sv
// Shared types, constants and control bundles of the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 32;
    localparam int ENTRY_W      = 2 * ADDR_W + 1;

    localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;
    localparam logic [1:0]  REG_HEAP_LIMIT = 2'd0;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2,
        CMD_CALLOC  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_NOHEAP   = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_PROD, S_ALLOC, S_FIND, S_FIT, S_GROW, S_AFTER, S_REL, S_DONE
    } t_state;

    // One block table entry as stored in memory
    typedef struct packed {
        logic              is_free;
        logic [ADDR_W-1:0] bytes;
        logic [ADDR_W-1:0] start;
    } t_entry;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    mul;
        logic    size_prod;
        logic    scan_init;
        logic    scan_step;
        logic    scan_fit;
        logic    take_found;
        logic    keep_addr;
        logic    fit_commit;
        logic    grow_commit;
        logic    mark_copy;
        logic    mark_zfill;
        logic    release_blk;
        logic    set_status;
        t_status status;
        logic    emit;
    } t_dp_ctl;

    // Status from datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic paddr_zero;
        logic size_zero;
        logic prod_zero;
        logic prod_ovf;
        logic hit;
        logic miss;
        logic data_fits;
        logic over_limit;
        logic table_full;
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/ffha_dp.sv
// Datapath: request registers, block table memory, scan pipeline, break and result.
`default_nettype none

module ffha_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ffha_pkg::t_dp_ctl i_ctl,
    output ffha_pkg::t_dp_stat    o_stat,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [31:0]      i_req_size,
    input  wire logic [31:0]      i_elem_size,
    input  wire logic [31:0]      i_payload_addr,
    input  wire logic [31:0]      i_heap_limit,
    output logic      [103:0]     o_result
);
    import ffha_pkg::*;

    // request
    t_cmd               r_cmd;
    logic [31:0]        r_req, r_esz, r_paddr, r_size;
    logic [63:0]        r_prod;
    // heap state
    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_break;
    // scan
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    // found entry
    logic [IDX_W-1:0]   r_fidx;
    logic [31:0]        r_fstart, r_fbytes;
    // result
    t_status            r_status;
    logic [31:0]        r_addr, r_cfrom, r_cbytes;
    logic               r_copy, r_zfill;
    logic [103:0]       r_out;

    t_entry             rd;
    logic [ENTRY_W-1:0] rdata;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    logic               match;
    logic [33:0]        top;
    logic               rel_last;

    assign rd = t_entry'(rdata);

    ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // scan compare, growth bound, last-block test
    always_comb begin
        if (i_ctl.scan_fit) begin
            match = rd.is_free && (rd.bytes >= r_size);
        end else begin
            match = ({1'b0, rd.start} + 33'(HEADER_BYTES)) == {1'b0, r_paddr};
        end
        top      = {2'b00, r_break} + 34'(HEADER_BYTES) + {2'b00, r_size};
        rel_last = ({1'b0, r_fidx} + CNT_W'(1)) == r_count;
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.paddr_zero = (r_paddr == '0);
        o_stat.size_zero  = (r_size == '0);
        o_stat.prod_zero  = (r_req == '0) || (r_esz == '0);
        o_stat.prod_ovf   = (r_prod[63:32] != '0);
        o_stat.hit        = r_pend && match;
        o_stat.miss       = !(r_pend && match) && (r_idx >= r_count);
        o_stat.data_fits  = rd.bytes >= r_req;
        o_stat.over_limit = top > {2'b00, i_heap_limit};
        o_stat.table_full = (r_count == CNT_W'(MAX_BLOCKS));
    end

    // table write port
    always_comb begin
        we    = 1'b0;
        waddr = r_fidx;
        wdata = '{is_free: 1'b1, bytes: r_fbytes, start: r_fstart};
        if (i_ctl.fit_commit) begin
            we    = 1'b1;
            waddr = r_pidx;
            wdata = '{is_free: 1'b0, bytes: rd.bytes, start: rd.start};
        end else if (i_ctl.grow_commit) begin
            we    = 1'b1;
            waddr = r_count[IDX_W-1:0];
            wdata = '{is_free: 1'b0, bytes: r_size, start: r_break};
        end else if (i_ctl.release_blk && !rel_last) begin
            we    = 1'b1;
        end
    end

    // heap control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_break <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_ctl.grow_commit) begin
                r_count <= r_count + CNT_W'(1);
                r_break <= top[31:0];
            end else if (i_ctl.release_blk && rel_last) begin
                r_count <= r_count - CNT_W'(1);
                r_break <= r_fstart;
            end
            if (i_ctl.scan_init) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_pend <= (r_idx < r_count);
                if (r_idx < r_count) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
        end
    end

    // request, found entry and result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_step) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
        if (i_ctl.load) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_req    <= i_req_size;
            r_esz    <= i_elem_size;
            r_paddr  <= i_payload_addr;
            r_size   <= i_req_size;
            r_status <= ST_OK;
            r_addr   <= '0;
            r_copy   <= 1'b0;
            r_cfrom  <= '0;
            r_cbytes <= '0;
            r_zfill  <= 1'b0;
        end
        if (i_ctl.mul) begin
            r_prod <= r_req * r_esz;
        end
        if (i_ctl.size_prod) begin
            r_size <= r_prod[31:0];
        end
        if (i_ctl.take_found) begin
            r_fidx   <= r_pidx;
            r_fstart <= rd.start;
            r_fbytes <= rd.bytes;
        end
        if (i_ctl.keep_addr) begin
            r_addr <= r_paddr;
        end
        if (i_ctl.fit_commit) begin
            r_addr <= rd.start + 32'(HEADER_BYTES);
        end
        if (i_ctl.grow_commit) begin
            r_addr <= r_break + 32'(HEADER_BYTES);
        end
        if (i_ctl.mark_copy) begin
            r_copy   <= 1'b1;
            r_cfrom  <= r_paddr;
            r_cbytes <= r_fbytes;
        end
        if (i_ctl.mark_zfill) begin
            r_zfill <= 1'b1;
        end
        if (i_ctl.set_status) begin
            r_status <= i_ctl.status;
        end
        if (i_ctl.emit) begin
            r_out <= {3'b000, r_zfill, r_cbytes, r_cfrom, r_copy, r_addr, r_status};
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

### hdl/ffha_ctrl.sv
// Controller: request sequencing state machine and output valid.
`default_nettype none

module ffha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_dp_ctl      o_ctl
);
    import ffha_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_ctl    = '0;
        o_ctl.status = ST_OK;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.cmd)
                    CMD_ALLOC: n_state = S_ALLOC;
                    CMD_CALLOC: begin
                        o_ctl.mul = 1'b1;
                        n_state   = S_PROD;
                    end
                    CMD_FREE, CMD_REALLOC: begin
                        if (!i_stat.paddr_zero) begin
                            o_ctl.scan_init = 1'b1;
                            n_state         = S_FIND;
                        end else if (i_stat.cmd == CMD_REALLOC) begin
                            n_state = S_ALLOC;
                        end else begin
                            o_ctl.set_status = 1'b1;
                            o_ctl.status     = ST_NULL;
                            n_state          = S_DONE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PROD: begin
                if (i_stat.prod_zero) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_NULL;
                    n_state          = S_DONE;
                end else if (i_stat.prod_ovf) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_OVERFLOW;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.size_prod = 1'b1;
                    n_state         = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_stat.size_zero) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_NULL;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.scan_init = 1'b1;
                    n_state         = S_FIT;
                end
            end
            // address match scan
            S_FIND: begin
                if (i_stat.hit) begin
                    o_ctl.take_found = 1'b1;
                    if (i_stat.cmd == CMD_FREE) begin
                        n_state = S_REL;
                    end else if (i_stat.data_fits) begin
                        o_ctl.keep_addr = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else if (i_stat.miss) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_UNKNOWN;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            // first-fit scan
            S_FIT: begin
                o_ctl.scan_fit = 1'b1;
                if (i_stat.hit) begin
                    o_ctl.fit_commit = 1'b1;
                    n_state          = S_AFTER;
                end else if (i_stat.miss) begin
                    n_state = S_GROW;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_GROW: begin
                if (i_stat.over_limit) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_NOHEAP;
                    n_state          = S_DONE;
                end else if (i_stat.table_full) begin
                    o_ctl.set_status = 1'b1;
                    o_ctl.status     = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.grow_commit = 1'b1;
                    n_state           = S_AFTER;
                end
            end
            S_AFTER: begin
                if (i_stat.cmd == CMD_REALLOC && !i_stat.paddr_zero) begin
                    o_ctl.mark_copy = 1'b1;
                    n_state         = S_REL;
                end else begin
                    o_ctl.mark_zfill = (i_stat.cmd == CMD_CALLOC);
                    n_state          = S_DONE;
                end
            end
            S_REL: begin
                o_ctl.release_blk = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

### hdl/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: stream ports, APB register, core.
//
// Requests enter on the s_axis channel: s_axis_tuser carries the command
// (alloc, free, realloc, calloc), s_axis_tdata the sizes and the payload
// address. Each transaction yields exactly one result transaction on m_axis.
// heap_limit is written over the APB port at address 0; the user is to write it only
// while the unit is idle, which the unit itself does not enforce. One request is in
// work at a time; s_axis_tready is high only in idle. Latency depends on the block
// table scan, one entry per cycle through the registered read port of the table
// memory; a realloc that moves its block runs an address scan, then a first-fit
// scan. The unit is ready for the next request in the cycle in which its result
// becomes valid.
// A finished result sits in the output register; the unit takes the next
// request while it waits, and holds the following result until m_axis_tready.
// Synchronous active-low reset empties the table and the break (no memory
// clearing pass is needed) and restores heap_limit to 65536.
`default_nettype none

module first_fit_heap_allocator_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] req_size, [63:32] elem_size, [95:64] payload_addr
    input  wire logic [95:0]  s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [2:0] status, [34:3] result_addr, [35] copy_needed, [67:36] copy_from,
    // [99:68] copy_bytes, [100] zero_fill_needed, [103:101] zero
    output logic      [103:0] m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import ffha_pkg::*;

    logic [31:0] r_heap_limit;
    t_dp_ctl     ctl;
    t_dp_stat    stat;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= HEAP_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr == REG_HEAP_LIMIT) begin
            r_heap_limit <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HEAP_LIMIT) ? r_heap_limit : '0;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    ffha_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_cmd          (s_axis_tuser),
        .i_req_size     (s_axis_tdata[31:0]),
        .i_elem_size    (s_axis_tdata[63:32]),
        .i_payload_addr (s_axis_tdata[95:64]),
        .i_heap_limit   (r_heap_limit),
        .o_result       (m_axis_tdata)
    );

endmodule

`default_nettype wire

### hdl/ffha_checker.sv
// Port-level assertions for the allocator and their bind to the top level.
`default_nettype none

module ffha_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);
    import ffha_pkg::*;

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // failed request grants no address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_OK || m_axis_tdata[34:3] == 32'd0))
        else $error("address on failed request");

    // copy and zero fill never together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[35] && m_axis_tdata[100]))
        else $error("copy and zero fill both set");

    // one request at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
